[rtl/rotated_page_framebuffer_plot_unit_macros.svh]
// Assertion macros used by the plot unit top level.
`ifndef ROTATED_PAGE_FRAMEBUFFER_PLOT_UNIT_MACROS_SVH
`define ROTATED_PAGE_FRAMEBUFFER_PLOT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RPFB_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`define RPFB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define RPFB_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg)

`define RPFB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

[rtl/rpfb_pkg.sv]
// Shared constants, codes and types of the rotated page framebuffer plot unit.
package rpfb_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_SIZE   = PANEL_WIDTH * PAGE_COUNT;
    localparam int ADDR_W       = $clog2(STORE_SIZE);
    localparam int CRD_W        = 9;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] ROT_0 = 2'd0;
    localparam logic [1:0] ROT_1 = 2'd1;
    localparam logic [1:0] ROT_2 = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] pos_x;
        logic [6:0] pos_y;
        logic       pixel_on;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } t_req;

    typedef struct packed {
        logic accept;
        logic sweep_wr;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic sweep_last;
        logic out_free;
    } t_sts;

endpackage

[rtl/rpfb_ifs.sv]
// Channel interfaces for requests, results and the rotation register write.
interface rpfb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [6:0] pos_x;
    logic [6:0] pos_y;
    logic       pixel_on;
    logic [2:0] read_page;
    logic [6:0] read_column;

    modport source (output valid, action, pos_x, pos_y, pixel_on, read_page, read_column,
                    input ready);
    modport sink (input valid, action, pos_x, pos_y, pixel_on, read_page, read_column,
                  output ready);
endinterface

interface rpfb_rsp_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] read_data;

    modport source (output valid, status, read_data, input ready);
    modport sink (input valid, status, read_data, output ready);
endinterface

interface rpfb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] rotation;

    modport source (output valid, rotation, input ready);
    modport sink (input valid, rotation, output ready);
endinterface

[rtl/rotated_page_framebuffer_plot_unit.sv]
// Top level of the rotated page framebuffer plot unit.
// A pixel write or byte read reads the store on the transfer; in the finish state, once the
// result register is free, an in-range write writes the modified byte back and the result register is loaded.
// Its result is offered from the result register after that commit; only one item is in flight at a time.
// A clear sweeps the store one byte a cycle and then commits its result in the finish state.
// After reset the store is swept to zero, all STORE_SIZE (1024) bytes, with no transfer accepted.
`include "rotated_page_framebuffer_plot_unit_macros.svh"

module rotated_page_framebuffer_plot_unit import rpfb_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    rpfb_req_if.sink   i_req,
    rpfb_rsp_if.source o_rsp,
    rpfb_cfg_if.sink   i_cfg
);

    t_req req;
    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    assign req.action      = i_req.action;
    assign req.pos_x       = i_req.pos_x;
    assign req.pos_y       = i_req.pos_y;
    assign req.pixel_on    = i_req.pixel_on;
    assign req.read_page   = i_req.read_page;
    assign req.read_column = i_req.read_column;

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;

    rpfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rpfb_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_rotation  (i_cfg.rotation),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (o_rsp.valid),
        .o_rsp_status    (o_rsp.status),
        .o_rsp_read_data (o_rsp.read_data)
    );

    `RPFB_ASSERT_SAME(a_commit_free, i_clk, i_rst_n, cmd.commit, sts.out_free, "result overwritten")
    `RPFB_ASSERT_SAME(a_sweep_blocks, i_clk, i_rst_n, cmd.sweep_wr, !req_ready, "sweep during intake")
    `RPFB_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && req_ready, !req_ready, "second transfer in flight")

endmodule

[rtl/rpfb_ctrl.sv]
// Controller state machine sequencing request transfers, commits and store sweeps.
module rpfb_ctrl import rpfb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_CLR  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.is_clear ? ST_CLR : ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_CLR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_FIN;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/rpfb_datapath.sv]
// Datapath with coordinate mapping, the frame store, sweep counter and result register.
module rpfb_datapath import rpfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_rotation,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic       i_rsp_ready,
    output logic       o_rsp_valid,
    output logic       o_rsp_status,
    output logic [7:0] o_rsp_read_data
);

    logic [7:0]        mem [STORE_SIZE];
    logic [1:0]        r_rotation;
    logic [ADDR_W-1:0] r_sweep;
    logic [1:0]        r_action;
    logic              r_on;
    logic [2:0]        r_bit;
    logic              r_status;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_rd_data;
    logic              r_out_valid;
    logic              r_out_status;
    logic [7:0]        r_out_data;

    logic [CRD_W-1:0]  x_w;
    logic [CRD_W-1:0]  y_w;
    logic [CRD_W-1:0]  px;
    logic [CRD_W-1:0]  py;
    logic              wr_in_range;
    logic              rd_in_range;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] acc_addr;
    logic              acc_bad;
    logic              sweep_last;
    logic              out_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        bit_mask;

    assign x_w = CRD_W'(i_req.pos_x);
    assign y_w = CRD_W'(i_req.pos_y);

    always_comb begin
        case (r_rotation)
            ROT_0: begin
                wr_in_range = (x_w < CRD_W'(PANEL_WIDTH)) && (y_w < CRD_W'(PANEL_HEIGHT));
                px          = x_w;
                py          = y_w;
            end
            ROT_1: begin
                wr_in_range = (x_w < CRD_W'(PANEL_HEIGHT)) && (y_w < CRD_W'(PANEL_WIDTH));
                px          = CRD_W'(PANEL_WIDTH - 1) - y_w;
                py          = x_w;
            end
            ROT_2: begin
                wr_in_range = (x_w < CRD_W'(PANEL_WIDTH)) && (y_w < CRD_W'(PANEL_HEIGHT));
                px          = CRD_W'(PANEL_WIDTH - 1) - x_w;
                py          = CRD_W'(PANEL_HEIGHT - 1) - y_w;
            end
            default: begin
                wr_in_range = (x_w < CRD_W'(PANEL_HEIGHT)) && (y_w < CRD_W'(PANEL_WIDTH));
                px          = y_w;
                py          = CRD_W'(PANEL_HEIGHT - 1) - x_w;
            end
        endcase
    end

    assign wr_addr = ADDR_W'(px) + ADDR_W'(py[CRD_W-1:3]) * ADDR_W'(PANEL_WIDTH);
    assign rd_addr = ADDR_W'(i_req.read_column)
                   + ADDR_W'(i_req.read_page) * ADDR_W'(PANEL_WIDTH);
    assign rd_in_range = (CRD_W'(i_req.read_page) < CRD_W'(PAGE_COUNT))
                      && (CRD_W'(i_req.read_column) < CRD_W'(PANEL_WIDTH));

    always_comb begin
        case (i_req.action)
            ACT_WRITE: begin
                acc_addr = wr_addr;
                acc_bad  = !wr_in_range;
            end
            ACT_READ: begin
                acc_addr = rd_addr;
                acc_bad  = !rd_in_range;
            end
            default: begin
                acc_addr = wr_addr;
                acc_bad  = 1'b0;
            end
        endcase
    end

    assign sweep_last = (r_sweep == ADDR_W'(STORE_SIZE - 1));
    assign out_free   = !r_out_valid || i_rsp_ready;
    assign bit_mask   = 8'b1 << r_bit;

    assign mem_we    = i_cmd.sweep_wr
                    || (i_cmd.commit && (r_action == ACT_WRITE) && !r_status);
    assign mem_waddr = i_cmd.sweep_wr ? r_sweep : r_addr;
    assign mem_wdata = i_cmd.sweep_wr ? 8'h00
                     : (r_on ? (r_rd_data | bit_mask) : (r_rd_data & ~bit_mask));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_rd_data <= mem[acc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_req.action;
            r_on     <= i_req.pixel_on;
            r_bit    <= py[2:0];
            r_status <= acc_bad;
            r_addr   <= acc_addr;
        end
        if (i_cmd.commit) begin
            r_out_status <= r_status;
            r_out_data   <= ((r_action == ACT_READ) && !r_status) ? r_rd_data : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation  <= ROT_0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rotation <= i_cfg_rotation;
            end
            if (i_cmd.sweep_wr) begin
                r_sweep <= sweep_last ? '0 : r_sweep + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_clear   = (i_req.action == ACT_CLEAR);
    assign o_sts.sweep_last = sweep_last;
    assign o_sts.out_free   = out_free;

    assign o_rsp_valid     = r_out_valid;
    assign o_rsp_status    = r_out_status;
    assign o_rsp_read_data = r_out_data;

endmodule

[sim/rpfb_plot_checker.sv]
// Checker that predicts every plot unit result and compares it with the result transfers.
module rpfb_plot_checker
    import rpfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rpfb_req_if  req,
    rpfb_rsp_if  rsp,
    rpfb_cfg_if  cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
    } t_plot_result;

    logic [7:0]   frame_mem [STORE_SIZE];
    logic [1:0]   rotation_q;
    t_plot_result result_q[$];
    int           mismatches;

    function automatic t_plot_result predict_plot(input t_req item);
        t_plot_result res;
        int x, y, px, py, idx, col, page;
        logic in_range;
        res = '0;
        x = item.pos_x;
        y = item.pos_y;
        col = item.read_column;
        page = item.read_page;
        px = 0;
        py = 0;
        case (item.action)
            ACT_WRITE: begin
                case (rotation_q)
                    ROT_0: begin
                        in_range = (x < PANEL_WIDTH) && (y < PANEL_HEIGHT);
                        px = x;
                        py = y;
                    end
                    ROT_1: begin
                        in_range = (x < PANEL_HEIGHT) && (y < PANEL_WIDTH);
                        px = PANEL_WIDTH - 1 - y;
                        py = x;
                    end
                    ROT_2: begin
                        in_range = (x < PANEL_WIDTH) && (y < PANEL_HEIGHT);
                        px = PANEL_WIDTH - 1 - x;
                        py = PANEL_HEIGHT - 1 - y;
                    end
                    default: begin
                        in_range = (x < PANEL_HEIGHT) && (y < PANEL_WIDTH);
                        px = y;
                        py = PANEL_HEIGHT - 1 - x;
                    end
                endcase
                if (!in_range) begin
                    res.status = 1'b1;
                end else begin
                    idx = px + (py / 8) * PANEL_WIDTH;
                    if (idx < STORE_SIZE) begin
                        frame_mem[idx][py % 8] = item.pixel_on;
                    end
                end
            end
            ACT_CLEAR: begin
                foreach (frame_mem[i]) frame_mem[i] = '0;
            end
            ACT_READ: begin
                if (page < PAGE_COUNT && col < PANEL_WIDTH) begin
                    res.read_data = frame_mem[col + page * PANEL_WIDTH];
                end else begin
                    res.status = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: result mismatch on %s: expected %0d, got %0d", $realtime, what,
                     want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_plot_result want;
        t_req         item;
        if (!i_rst_n) begin
            foreach (frame_mem[i]) frame_mem[i] = '0;
            rotation_q = ROT_0;
            result_q.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (result_q.size() == 0) begin
                    note_mismatch("unexpected result, status", -1, rsp.status);
                end else begin
                    want = result_q.pop_front();
                    if (rsp.status !== want.status) begin
                        note_mismatch("status", want.status, rsp.status);
                    end
                    if (rsp.read_data !== want.read_data) begin
                        note_mismatch("read_data", want.read_data, rsp.read_data);
                    end
                end
            end
            if (req.valid && req.ready) begin
                item.action      = req.action;
                item.pos_x       = req.pos_x;
                item.pos_y       = req.pos_y;
                item.pixel_on    = req.pixel_on;
                item.read_page   = req.read_page;
                item.read_column = req.read_column;
                result_q.push_back(predict_plot(item));
            end
            if (cfg.valid && cfg.ready) begin
                rotation_q = cfg.rotation;
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= result_q.size();
    end

endmodule

[sim/testbench.sv]
// Top of the plot unit testbench: clock, reset, stimulus, back-pressure and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rpfb_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int PHASES       = 6;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;
    localparam longint CYCLE_LIMIT = 1_000_000;

    logic   i_clk;
    logic   i_rst_n;
    int     fail_count;
    int     pending;
    bit     quiet;
    bit     hold_req;
    longint cycles = 0;

    rpfb_req_if req_ch ();
    rpfb_rsp_if rsp_ch ();
    rpfb_cfg_if cfg_ch ();

    rotated_page_framebuffer_plot_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    rpfb_plot_checker u_plot_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .cfg          (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic t_req random_fields();
        logic [31:0] bits;
        t_req        item;
        bits = $urandom;
        item = bits[$bits(t_req)-1:0];
        return item;
    endfunction

    function automatic t_req make_write(input int x, input int y, input logic on);
        t_req item;
        item = random_fields();
        item.action   = ACT_WRITE;
        item.pos_x    = 7'(x);
        item.pos_y    = 7'(y);
        item.pixel_on = on;
        return item;
    endfunction

    function automatic t_req make_read(input int page, input int col);
        t_req item;
        item = random_fields();
        item.action      = ACT_READ;
        item.read_page   = 3'(page);
        item.read_column = 7'(col);
        return item;
    endfunction

    function automatic t_req make_plain(input logic [1:0] act);
        t_req item;
        item = random_fields();
        item.action = act;
        return item;
    endfunction

    function automatic int corner_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(56, 63);
            2: return $urandom_range(120, 127);
            default: return $urandom_range(0, 127);
        endcase
    endfunction

    function automatic t_req random_item();
        int pick;
        t_req item;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            item = make_write(corner_coord(), corner_coord(), $urandom_range(0, 99) < 65);
        end else if (pick < 96) begin
            item = make_read($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                  : 7 * $urandom_range(0, 1),
                             $urandom_range(0, 1) ? $urandom_range(0, 127)
                                                  : ($urandom_range(0, 1) ?
                                                     $urandom_range(0, 7) :
                                                     $urandom_range(120, 127)));
        end else if (pick < 98) begin
            item = make_plain(ACT_CLEAR);
        end else begin
            item = make_plain(ACT_NONE);
        end
        return item;
    endfunction

    task automatic send_item(input t_req item);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= item.action;
        req_ch.pos_x       <= item.pos_x;
        req_ch.pos_y       <= item.pos_y;
        req_ch.pixel_on    <= item.pixel_on;
        req_ch.read_page   <= item.read_page;
        req_ch.read_column <= item.read_column;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_rotation(input logic [1:0] rot);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.rotation <= rot;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [1:0] rot;
        int xmax, ymax;
        quiet    = 1'b0;
        hold_req = 1'b0;
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_WRITE;
        req_ch.pos_x       <= '0;
        req_ch.pos_y       <= '0;
        req_ch.pixel_on    <= 1'b0;
        req_ch.read_page   <= '0;
        req_ch.read_column <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.rotation    <= ROT_0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            rot = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            write_rotation(rot);
            if (phase < 4) begin
                xmax = rot[0] ? PANEL_HEIGHT - 1 : PANEL_WIDTH - 1;
                ymax = rot[0] ? PANEL_WIDTH - 1 : PANEL_HEIGHT - 1;
                send_item(make_write(0, 0, 1'b1));
                send_item(make_write(xmax, ymax, 1'b1));
                send_item(rot[0] ? make_write(PANEL_HEIGHT, 0, 1'b1)
                                 : make_write(0, PANEL_HEIGHT, 1'b1));
                send_item(make_read(0, 0));
                send_item(make_read(PAGE_COUNT - 1, PANEL_WIDTH - 1));
                if (phase == 0) begin
                    send_item(make_write(127, 127, 1'b1));
                    send_item(make_plain(ACT_NONE));
                    send_item(make_plain(ACT_CLEAR));
                    send_item(make_read(PAGE_COUNT - 1, PANEL_WIDTH - 1));
                end
            end
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
                quiet = (phase == PHASES - 1) || ((i / 50) % 4 == 3);
                if (phase == 2 && i == 60) hold_req = 1'b1;
                send_item(random_item());
            end
            req_ch.valid <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
